FILE: src/glq_pkg.sv
// Shared types, constants and helpers for the glyph quad layout block.
// Used by glyph_quad_layout_top; has no dependencies of its own.
package glq_pkg;

    // Glyph table addressing.
    localparam int CODE_BITS   = 8;
    localparam int TABLE_DEPTH = 1 << CODE_BITS;
    localparam int CODE_W      = 21;

    // Field widths.
    localparam int TEXEL_W    = 12;
    localparam int SUM_W      = TEXEL_W + 1;
    localparam int SCALE_W    = 33;
    localparam int PROD_W     = SUM_W + SCALE_W;
    localparam int TEX_W      = 17;
    localparam int TEX_SHIFT  = 16;
    localparam int BASELINE_W = 12;
    localparam int ORIGIN_W   = 16;
    localparam int PEN_W      = 20;
    localparam int VY_W       = 18;

    // Stream payload widths.
    localparam int IN_DATA_W  = 144;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 96;

    // Configuration port.
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_BASELINE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_U_SCALE  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_V_SCALE  = 2'd2;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 33'd1048576;

    // Operation codes carried in tuser.
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_DRAW  = 2'd2;

    localparam logic [1:0] CORNER_LAST = 2'd3;

    // One glyph table entry: atlas rectangle and metrics.
    typedef struct packed {
        logic signed [TEXEL_W-1:0] advance;
        logic signed [TEXEL_W-1:0] offset_y;
        logic signed [TEXEL_W-1:0] offset_x;
        logic        [TEXEL_W-1:0] glyph_height;
        logic        [TEXEL_W-1:0] glyph_width;
        logic        [TEXEL_W-1:0] atlas_y;
        logic        [TEXEL_W-1:0] atlas_x;
    } glyph_entry_t;

    localparam int ENTRY_W = $bits(glyph_entry_t);

    // Product of texel and scale, shifted down by 16 and clamped to 1.16 range.
    function automatic logic [TEX_W-1:0] tex_saturate(input logic [PROD_W-1:0] prod);
        logic [TEX_W-1:0] result;
        if (|prod[PROD_W-1:TEX_SHIFT+TEX_W])
        begin
            result = '1;
        end
        else
        begin
            result = prod[TEX_SHIFT+TEX_W-1:TEX_SHIFT];
        end
        return result;
    endfunction

endpackage

FILE: src/glq_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; no package dependencies.
module glq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/glyph_quad_layout_top.sv
// Top level of the glyph quad layout block: glyph table, pen state and quad output.
// Depends on glq_pkg and glq_ram.
//
// Usage: items arrive on the s_axis channel with the operation in tuser.
// A write item stores a glyph entry at its code point and sets its valid bit;
// a start item loads the pen and line position; a draw item of a valid glyph
// yields four corner items on m_axis (tlast on the fourth) and moves the pen.
// Writes, starts, out-of-range codes and unwritten glyphs give no output.
// The cfg channel writes baseline, u_scale and v_scale; cfg_ready is always
// high. The user must make writes only while the block is idle; the block
// itself does not enforce this. The first corner of a draw is offered once the
// item has passed the glyph table read, then the geometry and texture products,
// then the quad register, which hands out one corner per cycle while the
// receiver is ready. A stalled receiver holds the current corner; the input
// keeps accepting until the stages behind the quad register are full. Reset
// clears the valid bits, the pen and the line position and sets the
// configuration to its reset values at once; the table contents themselves
// are not cleared and need no clearing pass.
module glyph_quad_layout_top (
    input  logic                               clk,
    input  logic                               rst_n,
    // Input stream.
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata from bit 0 up: code, atlas_x, atlas_y, glyph_width, glyph_height,
    // offset_x, offset_y, advance, origin_x, origin_y, zero fill.
    input  logic [glq_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // tuser: operation.
    input  logic [glq_pkg::IN_USER_W-1:0]      s_axis_tuser,
    // Output stream.
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata from bit 0 up: vertex_x, vertex_y, tex_u, tex_v, corner, pen_after,
    // zero fill.
    output logic [glq_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // tlast: last.
    output logic                               m_axis_tlast,
    // Configuration write channel.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [glq_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [glq_pkg::SCALE_W-1:0]        cfg_data
);

    localparam int ADDR_W = glq_pkg::CODE_BITS;

    // Input field extraction.
    logic [1:0]                          in_op;
    logic [glq_pkg::CODE_W-1:0]          in_code;
    glq_pkg::glyph_entry_t               in_entry;
    logic signed [glq_pkg::ORIGIN_W-1:0] in_origin_x;
    logic signed [glq_pkg::ORIGIN_W-1:0] in_origin_y;

    assign in_op                 = s_axis_tuser;
    assign in_code               = s_axis_tdata[20:0];
    assign in_entry.atlas_x      = s_axis_tdata[32:21];
    assign in_entry.atlas_y      = s_axis_tdata[44:33];
    assign in_entry.glyph_width  = s_axis_tdata[56:45];
    assign in_entry.glyph_height = s_axis_tdata[68:57];
    assign in_entry.offset_x     = s_axis_tdata[80:69];
    assign in_entry.offset_y     = s_axis_tdata[92:81];
    assign in_entry.advance      = s_axis_tdata[104:93];
    assign in_origin_x           = s_axis_tdata[120:105];
    assign in_origin_y           = s_axis_tdata[136:121];

    // Configuration registers.
    logic [glq_pkg::BASELINE_W-1:0] baseline_reg;
    logic [glq_pkg::SCALE_W-1:0]    u_scale_reg;
    logic [glq_pkg::SCALE_W-1:0]    v_scale_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            baseline_reg <= '0;
            u_scale_reg  <= glq_pkg::SCALE_RESET;
            v_scale_reg  <= glq_pkg::SCALE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                glq_pkg::CFG_BASELINE: baseline_reg <= cfg_data[glq_pkg::BASELINE_W-1:0];
                glq_pkg::CFG_U_SCALE:  u_scale_reg  <= cfg_data;
                glq_pkg::CFG_V_SCALE:  v_scale_reg  <= cfg_data;
                default:               ;
            endcase
        end
    end

    // Handshake chain: quad register <- stage 2 <- stage 1 <- input.
    logic s1_valid_reg, s1_draw_reg;
    logic s2_valid_reg;
    logic q_valid_reg;
    logic [1:0] corner_reg;
    logic q_free, s2_adv, s1_adv, in_accept, code_in_range, enter_s1, is_draw, is_start;

    assign q_free        = !q_valid_reg || (m_axis_tready && corner_reg == glq_pkg::CORNER_LAST);
    assign s2_adv        = s2_valid_reg && q_free;
    assign s1_adv        = s1_valid_reg && (!s1_draw_reg || !s2_valid_reg || s2_adv);
    assign s_axis_tready = !s1_valid_reg || s1_adv;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign code_in_range = (in_code[glq_pkg::CODE_W-1:ADDR_W] == '0);

    // Glyph valid bits, one per table entry.
    logic [glq_pkg::TABLE_DEPTH-1:0] glyph_valid_reg;

    assign is_start = (in_op == glq_pkg::OP_START);
    assign is_draw  = (in_op == glq_pkg::OP_DRAW) && code_in_range
                      && glyph_valid_reg[in_code[ADDR_W-1:0]];
    assign enter_s1 = in_accept && (is_start || is_draw);

    logic table_wr;
    assign table_wr = in_accept && (in_op == glq_pkg::OP_WRITE) && code_in_range;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glyph_valid_reg <= '0;
        end
        else if (table_wr)
        begin
            glyph_valid_reg[in_code[ADDR_W-1:0]] <= 1'b1;
        end
    end

    logic [glq_pkg::ENTRY_W-1:0] table_rd_data;
    glq_pkg::glyph_entry_t       entry;

    glq_ram #(
        .WIDTH (glq_pkg::ENTRY_W),
        .DEPTH (glq_pkg::TABLE_DEPTH)
    ) u_glyph_table (
        .clk     (clk),
        .wr_en   (table_wr),
        .wr_addr (in_code[ADDR_W-1:0]),
        .wr_data (in_entry),
        .rd_en   (enter_s1 && is_draw),
        .rd_addr (in_code[ADDR_W-1:0]),
        .rd_data (table_rd_data)
    );

    assign entry = table_rd_data;

    // Stage 1: item waiting for its table entry to be used.
    logic signed [glq_pkg::ORIGIN_W-1:0] s1_origin_x_reg, s1_origin_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= enter_s1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enter_s1)
        begin
            s1_draw_reg     <= is_draw;
            s1_origin_x_reg <= in_origin_x;
            s1_origin_y_reg <= in_origin_y;
        end
    end

    // Pen state and quad geometry.
    logic [glq_pkg::PEN_W-1:0]    pen_x_reg;
    logic [glq_pkg::ORIGIN_W-1:0] line_y_reg;
    logic [glq_pkg::PEN_W-1:0]    left_next, right_next, after_next;
    logic [glq_pkg::VY_W-1:0]     top_next, bottom_next;
    logic [glq_pkg::SUM_W-1:0]    u_far, v_far;
    logic [glq_pkg::PROD_W-1:0]   prod_u0_next, prod_u1_next, prod_v0_next, prod_v1_next;

    always_comb
    begin
        left_next   = pen_x_reg + glq_pkg::PEN_W'(entry.offset_x);
        right_next  = left_next + glq_pkg::PEN_W'(entry.glyph_width);
        after_next  = pen_x_reg + glq_pkg::PEN_W'(entry.advance);
        top_next    = glq_pkg::VY_W'($signed(line_y_reg))
                      + glq_pkg::VY_W'(baseline_reg)
                      - glq_pkg::VY_W'(entry.offset_y);
        bottom_next = top_next - glq_pkg::VY_W'(entry.glyph_height);
        u_far       = glq_pkg::SUM_W'(entry.atlas_x) + glq_pkg::SUM_W'(entry.glyph_width);
        v_far       = glq_pkg::SUM_W'(entry.atlas_y) + glq_pkg::SUM_W'(entry.glyph_height);
        prod_u0_next = glq_pkg::PROD_W'(entry.atlas_x) * glq_pkg::PROD_W'(u_scale_reg);
        prod_u1_next = glq_pkg::PROD_W'(u_far)         * glq_pkg::PROD_W'(u_scale_reg);
        prod_v0_next = glq_pkg::PROD_W'(entry.atlas_y) * glq_pkg::PROD_W'(v_scale_reg);
        prod_v1_next = glq_pkg::PROD_W'(v_far)         * glq_pkg::PROD_W'(v_scale_reg);
    end

    // The pen is updated in item order as each start or draw leaves stage 1.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_x_reg  <= '0;
            line_y_reg <= '0;
        end
        else if (s1_adv)
        begin
            if (s1_draw_reg)
            begin
                pen_x_reg <= after_next;
            end
            else
            begin
                pen_x_reg  <= glq_pkg::PEN_W'(s1_origin_x_reg);
                line_y_reg <= s1_origin_y_reg;
            end
        end
    end

    // Stage 2: geometry and raw texture products.
    logic [glq_pkg::PEN_W-1:0]  s2_left_reg, s2_right_reg, s2_after_reg;
    logic [glq_pkg::VY_W-1:0]   s2_top_reg, s2_bottom_reg;
    logic [glq_pkg::PROD_W-1:0] s2_u0_reg, s2_u1_reg, s2_v0_reg, s2_v1_reg;
    logic                       s2_load;

    assign s2_load = s1_adv && s1_draw_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_load)
        begin
            s2_valid_reg <= 1'b1;
        end
        else if (s2_adv)
        begin
            s2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            s2_left_reg   <= left_next;
            s2_right_reg  <= right_next;
            s2_after_reg  <= after_next;
            s2_top_reg    <= top_next;
            s2_bottom_reg <= bottom_next;
            s2_u0_reg     <= prod_u0_next;
            s2_u1_reg     <= prod_u1_next;
            s2_v0_reg     <= prod_v0_next;
            s2_v1_reg     <= prod_v1_next;
        end
    end

    // Quad register: holds one quad and hands out its corners in order.
    logic [glq_pkg::PEN_W-1:0] q_left_reg, q_right_reg, q_after_reg;
    logic [glq_pkg::VY_W-1:0]  q_top_reg, q_bottom_reg;
    logic [glq_pkg::TEX_W-1:0] q_u0_reg, q_u1_reg, q_v0_reg, q_v1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_valid_reg <= 1'b0;
            corner_reg  <= '0;
        end
        else if (s2_adv)
        begin
            q_valid_reg <= 1'b1;
            corner_reg  <= '0;
        end
        else if (m_axis_tvalid && m_axis_tready)
        begin
            if (corner_reg == glq_pkg::CORNER_LAST)
            begin
                q_valid_reg <= 1'b0;
            end
            corner_reg <= corner_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_adv)
        begin
            q_left_reg   <= s2_left_reg;
            q_right_reg  <= s2_right_reg;
            q_after_reg  <= s2_after_reg;
            q_top_reg    <= s2_top_reg;
            q_bottom_reg <= s2_bottom_reg;
            q_u0_reg     <= glq_pkg::tex_saturate(s2_u0_reg);
            q_u1_reg     <= glq_pkg::tex_saturate(s2_u1_reg);
            q_v0_reg     <= glq_pkg::tex_saturate(s2_v0_reg);
            q_v1_reg     <= glq_pkg::tex_saturate(s2_v1_reg);
        end
    end

    // Corners 1 and 2 are on the right, corners 2 and 3 on the bottom.
    logic                      on_right, on_bottom;
    logic [glq_pkg::PEN_W-1:0] vertex_x;
    logic [glq_pkg::VY_W-1:0]  vertex_y;
    logic [glq_pkg::TEX_W-1:0] tex_u, tex_v;

    assign on_right  = corner_reg[0] ^ corner_reg[1];
    assign on_bottom = corner_reg[1];
    assign vertex_x  = on_right  ? q_right_reg  : q_left_reg;
    assign tex_u     = on_right  ? q_u1_reg     : q_u0_reg;
    assign vertex_y  = on_bottom ? q_bottom_reg : q_top_reg;
    assign tex_v     = on_bottom ? q_v1_reg     : q_v0_reg;

    assign m_axis_tvalid = q_valid_reg;
    assign m_axis_tlast  = (corner_reg == glq_pkg::CORNER_LAST);
    assign m_axis_tdata  = {2'b00, q_after_reg, corner_reg, tex_v, tex_u, vertex_y, vertex_x};

endmodule
